// ----- rtl/core/elptc_pkg.sv -----
// Shared types and constants for the extended low-power timer compare block.
// No dependencies.
package elptc_pkg;

	typedef enum logic [2:0] {
		ACT_TICK        = 3'd0,
		ACT_DELAY_TICKS = 3'd1,
		ACT_ABS         = 3'd2,
		ACT_DELAY_MS    = 3'd3,
		ACT_DELAY_US    = 3'd4,
		ACT_READ        = 3'd5,
		ACT_ROLL        = 3'd6,
		ACT_NONE        = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_LONG  = 2'd2
	} status_t;

	localparam logic REG_GUARD = 1'b0;
	localparam logic REG_EXTRA = 1'b1;

	// floor(x / d) via floor(x * floor(2^32 / d) / 2^32) plus one correction
	localparam logic [25:0] RECIP_MS  = 26'd34359738;
	localparam logic [25:0] RECIP_US  = 26'd274877;
	localparam logic [13:0] DIV_MS    = 14'd125;
	localparam logic [13:0] DIV_US    = 14'd15625;
	localparam logic [31:0] MS_LIMIT  = 32'd2000;
	localparam logic [31:0] US_LIMIT  = 32'd2000000;
	localparam logic [13:0] US_SCALE  = 14'd15625;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		act_t        act;
		logic        ch;
		logic [15:0] ticks;
		logic        next_epoch;
		logic        too_long;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_st_t;

	typedef struct packed {
		logic task_armed;
		logic cmp0_en;
	} arm_st_t;

endpackage

// ----- rtl/core/elptc_front.sv -----
// Front end: accepts input items, converts ms/us delays to ticks.
// Depends on elptc_pkg.
module elptc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [55:0]            s_tdata,
	input  logic [3:0]             s_tuser,
	input  elptc_pkg::fifo_st_t    q_st,
	output logic                   push,
	output elptc_pkg::item_t       push_item
);
	import elptc_pkg::*;

	logic        v_s1;
	act_t        act_s1;
	logic        ch_s1;
	logic [15:0] ticks_s1;
	logic        next_s1;
	logic        long_s1;
	logic [29:0] x_s1;
	logic [15:0] qe_s1;

	act_t        act_in;
	logic [31:0] amount;
	logic        is_ms;
	logic [29:0] x;
	logic [25:0] recip;
	logic [55:0] prod;
	logic        accept;
	logic [13:0] d;
	logic [29:0] qd;
	logic [29:0] rem;
	logic [15:0] q;
	logic        scaled;

	assign act_in = act_t'(s_tuser[2:0]);
	assign amount = s_tdata[47:16];
	assign is_ms  = (act_in == ACT_DELAY_MS);
	assign x      = is_ms ? {7'd0, amount[10:0], 12'd0} : {amount[20:0], 9'd0};
	assign recip  = is_ms ? RECIP_MS : RECIP_US;
	assign prod   = 56'(x) * 56'(recip);

	assign push     = v_s1 && !q_st.full;
	assign s_tready = !v_s1 || !q_st.full;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= act_in;
			ch_s1    <= s_tuser[3];
			ticks_s1 <= s_tdata[15:0];
			next_s1  <= s_tdata[48];
			long_s1  <= is_ms ? (amount >= MS_LIMIT) : (amount >= US_LIMIT);
			x_s1     <= x;
			qe_s1    <= prod[47:32];
		end
	end

	assign d      = (act_s1 == ACT_DELAY_MS) ? DIV_MS : DIV_US;
	assign qd     = 30'(qe_s1) * 30'(d);
	assign rem    = x_s1 - qd;
	assign q      = (rem >= 30'(d)) ? qe_s1 + 16'd1 : qe_s1;
	assign scaled = (act_s1 == ACT_DELAY_MS) || (act_s1 == ACT_DELAY_US);

	always_comb begin
		push_item.act        = act_s1;
		push_item.ch         = ch_s1;
		push_item.ticks      = scaled ? q : ticks_s1;
		push_item.next_epoch = next_s1;
		push_item.too_long   = scaled && long_s1;
	end

endmodule

// ----- rtl/core/elptc_fifo.sv -----
// Short item queue between front end and back end.
// Depends on elptc_pkg.
module elptc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  elptc_pkg::item_t      push_item,
	input  logic                  pop,
	output elptc_pkg::item_t      head,
	output elptc_pkg::fifo_st_t   st
);
	import elptc_pkg::*;

	item_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign st.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign st.empty = (cnt_q == '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

// ----- rtl/core/elptc_back.sv -----
// Back end: timer state, compare arming and firing, time read and output register.
// Depends on elptc_pkg.
module elptc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  elptc_pkg::item_t      head,
	input  elptc_pkg::fifo_st_t   q_st,
	output logic                  pop,
	input  logic [7:0]            guard_ticks,
	input  logic [7:0]            extra_ticks,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [111:0]          m_tdata,
	output elptc_pkg::arm_st_t    arm_st
);
	import elptc_pkg::*;

	logic [15:0] low_q [2];
	logic [31:0] ep_q  [2];
	logic [15:0] cv_q  [2];
	logic [1:0]  ce_q;
	logic        ta_q;
	logic        rf_q;

	logic [15:0] low_n [2];
	logic [31:0] ep_n  [2];
	logic [15:0] cv_n  [2];
	logic [1:0]  ce_n;
	logic        ta_n;
	logic        rf_n;

	status_t     st;
	logic [2:0]  fl;
	logic [47:0] tt;
	logic [16:0] now;
	logic [15:0] lo_ch;
	logic [15:0] sum;

	logic        v_s1;
	status_t     st_s1;
	logic [2:0]  fl_s1;
	logic [47:0] tt_s1;
	logic [37:0] plo_s1;
	logic [37:0] phi_s1;

	logic        o_valid_q;
	logic [111:0] o_data_q;
	logic        adv_o;
	logic [61:0] us_full;

	assign adv_o = v_s1 && (!o_valid_q || m_tready);
	assign pop   = !q_st.empty && (!v_s1 || adv_o);

	assign lo_ch = low_q[head.ch];
	assign now   = {1'b0, lo_ch} + 17'(extra_ticks);
	assign sum   = lo_ch + head.ticks + 16'(extra_ticks);

	always_comb begin
		low_n = low_q;
		ep_n  = ep_q;
		cv_n  = cv_q;
		ce_n  = ce_q;
		ta_n  = ta_q;
		rf_n  = rf_q;
		st    = ST_OK;
		fl    = '0;
		tt    = '0;
		unique case (head.act)
			ACT_TICK: begin
				for (int c = 0; c < 2; c++) begin
					low_n[c] = low_q[c] + 16'd1;
					if (low_n[c] == '0) begin
						ep_n[c] = ep_q[c] + 32'd1;
						if (c == 1 && rf_q) begin
							rf_n  = 1'b0;
							fl[2] = 1'b1;
						end
					end
					if (ce_q[c] && low_n[c] == cv_q[c]) begin
						ce_n[c] = 1'b0;
						if (c == 0) begin
							if (ta_q) begin
								ta_n  = 1'b0;
								fl[0] = 1'b1;
							end
						end else begin
							fl[1] = 1'b1;
						end
					end
				end
			end
			ACT_DELAY_TICKS, ACT_DELAY_MS, ACT_DELAY_US: begin
				if (head.too_long) begin
					st = ST_LONG;
				end else if (head.ticks <= 16'(guard_ticks)) begin
					st = ST_SHORT;
				end else begin
					cv_n[head.ch] = sum;
					ce_n[head.ch] = 1'b1;
					if (!head.ch) ta_n = 1'b1;
				end
			end
			ACT_ABS: begin
				if (!head.ch && ta_q) begin
					ta_n    = 1'b0;
					ce_n[0] = 1'b0;
				end
				if (now > 17'(head.ticks) && !head.next_epoch) begin
					st = ST_SHORT;
				end else if (now < 17'(head.ticks) && head.next_epoch) begin
					st = ST_LONG;
				end else begin
					cv_n[head.ch] = head.ticks;
					ce_n[head.ch] = 1'b1;
					if (!head.ch) ta_n = 1'b1;
				end
			end
			ACT_READ: begin
				tt = {ep_q[head.ch], lo_ch};
			end
			ACT_ROLL: begin
				rf_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '{default: '0};
			ep_q  <= '{default: '0};
			cv_q  <= '{default: '0};
			ce_q  <= '0;
			ta_q  <= 1'b0;
			rf_q  <= 1'b0;
		end else if (pop) begin
			low_q <= low_n;
			ep_q  <= ep_n;
			cv_q  <= cv_n;
			ce_q  <= ce_n;
			ta_q  <= ta_n;
			rf_q  <= rf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (pop)        v_s1 <= 1'b1;
			else if (adv_o) v_s1 <= 1'b0;
			if (adv_o)         o_valid_q <= 1'b1;
			else if (m_tready) o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			st_s1  <= st;
			fl_s1  <= fl;
			tt_s1  <= tt;
			plo_s1 <= 38'(tt[23:0]) * 38'(US_SCALE);
			phi_s1 <= 38'(tt[47:24]) * 38'(US_SCALE);
		end
	end

	assign us_full = {phi_s1[37:0], 24'd0} + 62'(plo_s1);

	always_ff @(posedge clk) begin
		if (adv_o) o_data_q <= {6'd0, fl_s1, us_full[61:9], tt_s1, st_s1};
	end

	assign m_tvalid       = o_valid_q;
	assign m_tdata        = o_data_q;
	assign arm_st.task_armed = ta_q;
	assign arm_st.cmp0_en    = ce_q[0];

endmodule

// ----- rtl/core/extended_lowpower_timer_compare.sv -----
// Two-channel 48-bit slow-clock timer with one-shot compare: top level.
// Depends on elptc_pkg, elptc_front, elptc_fifo, elptc_back.
// Items are ticks, arm requests and time reads; a new item is accepted every
// cycle unless the queue is full with the front stage occupied. m_tvalid rises
// once the item has passed the front stage (ms/us conversion multiply), the
// queue, the back stage (timer state update and microsecond partial products)
// and the output register. The queue holds four items between front and back.
module extended_lowpower_timer_compare (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ticks[15:0], amount[47:16], next_epoch[48], zero fill
	input  logic [55:0]  s_tdata,
	// action[2:0], channel[3]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], time_ticks[49:2], time_us[102:50], task_fire[103],
	// vt_compare_fire[104], vt_roll_fire[105], zero fill
	output logic [111:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import elptc_pkg::*;

	logic [7:0] guard_q;
	logic [7:0] extra_q;
	logic       push;
	logic       pop;
	item_t      push_item;
	item_t      head;
	fifo_st_t   q_st;
	arm_st_t    arm_st;

	assign pready = 1'b1;
	assign prdata = {24'd0, (paddr[2] == REG_EXTRA) ? extra_q : guard_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= 8'd2;
			extra_q <= 8'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_GUARD) guard_q <= pwdata[7:0];
			else                       extra_q <= pwdata[7:0];
		end
	end

	elptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_st      (q_st),
		.push      (push),
		.push_item (push_item)
	);

	elptc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.st        (q_st)
	);

	elptc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_st        (q_st),
		.pop         (pop),
		.guard_ticks (guard_q),
		.extra_ticks (extra_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.arm_st      (arm_st)
	);

`ifndef SYNTHESIS
	a_task_arm: assert property (@(posedge clk) disable iff (!arst_n)
		arm_st.task_armed |-> arm_st.cmp0_en)
		else $error("task armed without channel 0 compare enabled");

	a_fire_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[103] || m_tdata[104] || m_tdata[105]))
		|-> (m_tdata[1:0] == ST_OK && m_tdata[49:2] == '0))
		else $error("fire flag on a non-tick item");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_st.empty |-> !pop)
		else $error("queue popped while empty");
`endif

endmodule

// ----- verif/elptc_checker.sv -----
// Checker for extended_lowpower_timer_compare: watches the input, output and register channels,
// predicts each result item and compares it field by field in arrival order.
// Depends on elptc_pkg.
module elptc_checker
	import elptc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [55:0]  s_tdata,
	input  logic [3:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic        vt_roll_fire;
		logic        vt_cmp_fire;
		logic        task_fire;
		logic [52:0] time_us;
		logic [47:0] time_ticks;
		logic [1:0]  status;
	} timer_result_t;

	logic [7:0]  guard_ticks, extra_ticks;
	logic [15:0] low_count[2];
	logic [31:0] epoch_count[2];
	logic [15:0] cmp_value[2];
	logic        cmp_en[2];
	logic        task_armed, roll_armed;

	timer_result_t expected_q[$];

	function automatic logic [1:0] arm_rel(input logic ch, input logic [31:0] delay);
		if (delay <= guard_ticks) return ST_SHORT;
		cmp_value[ch] = low_count[ch] + delay[15:0] + extra_ticks;
		cmp_en[ch] = 1'b1;
		if (!ch) task_armed = 1'b1;
		return ST_OK;
	endfunction

	function automatic logic [1:0] arm_abs(input logic ch, input logic [15:0] target,
			input logic nxt);
		logic [16:0] now;
		if (!ch && task_armed) begin
			task_armed = 1'b0;
			cmp_en[0] = 1'b0;
		end
		now = low_count[ch] + extra_ticks;
		if (now > target && !nxt) return ST_SHORT;
		if (now < target && nxt) return ST_LONG;
		cmp_value[ch] = target;
		cmp_en[ch] = 1'b1;
		if (!ch) task_armed = 1'b1;
		return ST_OK;
	endfunction

	function automatic logic [1:0] arm_scaled(input logic ch, input logic [63:0] amt,
			input logic [63:0] div);
		logic [63:0] t;
		t = amt * 64'd32768 / div;
		if (t > 64'hFFFF) return ST_LONG;
		return arm_rel(ch, t[31:0]);
	endfunction

	function automatic timer_result_t timer_step(input act_t act, input logic ch,
			input logic [15:0] tk, input logic [31:0] amt, input logic nxt);
		timer_result_t r;
		logic [63:0] t;
		r = '0;
		case (act)
			ACT_TICK: begin
				for (int c = 0; c < 2; c++) begin
					low_count[c] = low_count[c] + 16'd1;
					if (low_count[c] == 16'd0) begin
						epoch_count[c] = epoch_count[c] + 32'd1;
						if (c == 1 && roll_armed) begin
							roll_armed = 1'b0;
							r.vt_roll_fire = 1'b1;
						end
					end
					if (cmp_en[c] && low_count[c] == cmp_value[c]) begin
						cmp_en[c] = 1'b0;
						if (c == 0) begin
							if (task_armed) begin
								task_armed = 1'b0;
								r.task_fire = 1'b1;
							end
						end else begin
							r.vt_cmp_fire = 1'b1;
						end
					end
				end
			end
			ACT_DELAY_TICKS: r.status = arm_rel(ch, {16'd0, tk});
			ACT_ABS:         r.status = arm_abs(ch, tk, nxt);
			ACT_DELAY_MS:    r.status = arm_scaled(ch, {32'd0, amt}, 64'd1000);
			ACT_DELAY_US:    r.status = arm_scaled(ch, {32'd0, amt}, 64'd1000000);
			ACT_READ: begin
				t = {epoch_count[ch], low_count[ch]};
				r.time_ticks = t[47:0];
				t = (t * 64'd15625) >> 9;
				r.time_us = t[52:0];
			end
			ACT_ROLL: roll_armed = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		timer_result_t exp_r, got;
		if (!arst_n) begin
			guard_ticks <= 8'd2;
			extra_ticks <= 8'd0;
			low_count[0] = '0; low_count[1] = '0;
			epoch_count[0] = '0; epoch_count[1] = '0;
			cmp_value[0] = '0; cmp_value[1] = '0;
			cmp_en[0] = 1'b0; cmp_en[1] = 1'b0;
			task_armed = 1'b0;
			roll_armed = 1'b0;
			errors = 0;
			expected_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[105:0];
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result item %h", $time, m_tdata);
					errors++;
				end else begin
					exp_r = expected_q.pop_front();
					if (got.status !== exp_r.status) begin
						$display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
						errors++;
					end
					if (got.time_ticks !== exp_r.time_ticks) begin
						$display("%0t: time_ticks exp %h got %h", $time,
							exp_r.time_ticks, got.time_ticks);
						errors++;
					end
					if (got.time_us !== exp_r.time_us) begin
						$display("%0t: time_us exp %h got %h", $time, exp_r.time_us, got.time_us);
						errors++;
					end
					if (got.task_fire !== exp_r.task_fire) begin
						$display("%0t: task_fire exp %b got %b", $time,
							exp_r.task_fire, got.task_fire);
						errors++;
					end
					if (got.vt_cmp_fire !== exp_r.vt_cmp_fire) begin
						$display("%0t: vt_compare_fire exp %b got %b", $time,
							exp_r.vt_cmp_fire, got.vt_cmp_fire);
						errors++;
					end
					if (got.vt_roll_fire !== exp_r.vt_roll_fire) begin
						$display("%0t: vt_roll_fire exp %b got %b", $time,
							exp_r.vt_roll_fire, got.vt_roll_fire);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(timer_step(act_t'(s_tuser[2:0]), s_tuser[3],
					s_tdata[15:0], s_tdata[47:16], s_tdata[48]));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_GUARD) guard_ticks <= pwdata[7:0];
				else                       extra_ticks <= pwdata[7:0];
			end
		end
	end

endmodule

// ----- verif/extended_lowpower_timer_compare_tb.sv -----
// Testbench top for extended_lowpower_timer_compare: clock, reset, stimulus and verdict.
// Depends on elptc_pkg, the block and elptc_checker.
module extended_lowpower_timer_compare_tb;
	import elptc_pkg::*;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready;
	logic [55:0]  s_tdata;
	logic [3:0]   s_tuser;
	logic         m_tvalid, m_tready;
	logic [111:0] m_tdata;
	logic         psel, penable, pwrite, pready;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;
	int           errors, pending;
	int           send_idle, recv_idle;
	logic         hold_req;
	int           cycles;

	extended_lowpower_timer_compare uut (.*);

	elptc_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int held;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (held = 0; held < 300; held++) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_item(input act_t act, input logic ch, input logic [15:0] tk,
			input logic [31:0] amt, input logic nxt);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {ch, act};
		s_tdata  <= {7'd0, nxt, amt, tk};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain_and_config(input logic [7:0] guard, input logic [7:0] extra);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		reg_write({REG_GUARD, 2'b00}, {24'($urandom), guard});
		reg_write({REG_EXTRA, 2'b00}, {24'($urandom), extra});
	endtask

	task automatic random_item();
		int w;
		logic ch;
		logic [15:0] tk;
		logic [31:0] amt;
		logic nxt;
		w   = $urandom_range(99);
		ch  = 1'($urandom_range(1));
		tk  = 16'($urandom);
		amt = $urandom;
		nxt = 1'($urandom_range(1));
		if (w < 50)
			send_item(ACT_TICK, ch, tk, amt, nxt);
		else if (w < 62)
			send_item(ACT_DELAY_TICKS, ch,
				($urandom_range(3) == 0) ? tk : 16'($urandom_range(300)), amt, nxt);
		else if (w < 70)
			send_item(ACT_ABS, ch,
				($urandom_range(3) == 0) ? tk : 16'($urandom_range(1500)), amt, nxt);
		else if (w < 77)
			send_item(ACT_DELAY_MS, ch, tk,
				($urandom_range(3) == 0) ? amt : $urandom_range(12), nxt);
		else if (w < 84)
			send_item(ACT_DELAY_US, ch, tk,
				($urandom_range(3) == 0) ? amt : $urandom_range(12000), nxt);
		else if (w < 93)
			send_item(ACT_READ, ch, tk, amt, nxt);
		else if (w < 97)
			send_item(ACT_ROLL, ch, tk, amt, nxt);
		else
			send_item(ACT_NONE, ch, tk, amt, nxt);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		send_idle = 21; recv_idle = 58;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every action, boundary delays
		send_item(ACT_READ, 1'b0, 16'd0, 32'd0, 1'b0);
		send_item(ACT_DELAY_TICKS, 1'b0, 16'd2, 32'd0, 1'b0);
		send_item(ACT_DELAY_TICKS, 1'b0, 16'd3, 32'd0, 1'b0);
		send_item(ACT_DELAY_TICKS, 1'b1, 16'd65535, 32'hFFFFFFFF, 1'b1);
		send_item(ACT_DELAY_MS, 1'b1, 16'hFFFF, 32'd1999, 1'b0);
		send_item(ACT_DELAY_MS, 1'b1, 16'd0, 32'd2000, 1'b0);
		send_item(ACT_DELAY_MS, 1'b0, 16'd0, 32'hFFFFFFFF, 1'b0);
		send_item(ACT_DELAY_US, 1'b1, 16'd0, 32'd1999999, 1'b0);
		send_item(ACT_DELAY_US, 1'b0, 16'd0, 32'd2000000, 1'b0);
		send_item(ACT_DELAY_US, 1'b1, 16'd0, 32'd0, 1'b0);
		send_item(ACT_DELAY_US, 1'b1, 16'd0, 32'd120, 1'b0);
		repeat (4) send_item(ACT_TICK, 1'b1, 16'd0, 32'd0, 1'b0);
		send_item(ACT_ABS, 1'b0, 16'd2, 32'd0, 1'b0);
		send_item(ACT_ABS, 1'b0, 16'd9, 32'd0, 1'b0);
		send_item(ACT_ABS, 1'b1, 16'd65535, 32'd0, 1'b1);
		send_item(ACT_ABS, 1'b1, 16'd0, 32'd0, 1'b1);
		send_item(ACT_ROLL, 1'b1, 16'd0, 32'd0, 1'b0);
		send_item(ACT_NONE, 1'b1, 16'hFFFF, 32'hFFFFFFFF, 1'b1);
		repeat (6) send_item(ACT_TICK, 1'b0, 16'hFFFF, 32'hFFFFFFFF, 1'b1);
		send_item(ACT_READ, 1'b1, 16'd0, 32'd0, 1'b0);

		drain_and_config(8'd0, 8'd0);
		repeat (300) random_item();
		drain_and_config(8'd255, 8'd255);
		repeat (250) random_item();

		send_idle = 58; recv_idle = 21;
		drain_and_config(8'($urandom), 8'($urandom));
		repeat (300) random_item();

		send_idle = 0; recv_idle = 0;
		drain_and_config(8'd2, 8'd0);
		hold_req = 1'b1;
		repeat (100) random_item();
		// roll arm, next-epoch compare, short tick run
		send_item(ACT_ROLL, 1'b0, 16'd0, 32'd0, 1'b0);
		send_item(ACT_ABS, 1'b1, 16'd40, 32'd0, 1'b1);
		repeat (20) send_item(ACT_TICK, 1'b0, 16'd0, 32'd0, 1'b0);
		send_item(ACT_READ, 1'b0, 16'd0, 32'd0, 1'b0);
		send_item(ACT_READ, 1'b1, 16'd0, 32'd0, 1'b0);
		drain_and_config(8'($urandom), 8'($urandom));
		repeat (300) random_item();
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
